### sv/mfb_pkg.sv
// shared types and codes for the monochrome framebuffer blitter
package mfb_pkg;

  localparam logic [1:0] ACT_BLIT = 2'd0;
  localparam logic [1:0] ACT_READ = 2'd1;
  localparam logic [1:0] ACT_FILL = 2'd2;

  localparam logic [1:0] REG_DEST_X     = 2'd0;
  localparam logic [1:0] REG_DEST_Y     = 2'd1;
  localparam logic [1:0] REG_IMG_WIDTH  = 2'd2;
  localparam logic [1:0] REG_IMG_HEIGHT = 2'd3;

  localparam logic [7:0]  WHITE   = 8'hFF;
  localparam logic [15:0] ROW_MAX = 16'hFFFF;

  typedef struct packed {
    logic [15:0] dest_x;
    logic [15:0] dest_y;
    logic [15:0] img_width;
    logic [15:0] img_height;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_MASK,
    ST_WR0,
    ST_WR1,
    ST_RDOUT,
    ST_FILL
  } state_t;

endpackage

### sv/mfb_ram.sv
// generic simple dual-port ram with registered read
module mfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 48000,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### sv/mfb_ctrl.sv
// sequencer for blit read-modify-write, reads and fill / clearing sweeps
module mfb_ctrl #(
  parameter int SCREEN_WIDTH = 800,
  parameter int SCREEN_HEIGHT = 480,
  localparam int ROW_BYTES = (SCREEN_WIDTH + 7) / 8,
  localparam int STORE_BYTES = ROW_BYTES * SCREEN_HEIGHT,
  localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  mfb_pkg::cfg_t cfg,
  input  logic          start,
  input  logic [1:0]    in_action,
  input  logic [7:0]    in_image_byte,
  input  logic          in_first_byte,
  input  logic [15:0]   in_read_address,
  input  logic [7:0]    in_fill_value,
  output logic          busy,
  output logic          out_valid,
  output logic [7:0]    out_read_data,
  output logic          ram_wr_en,
  output logic [AW-1:0] ram_wr_addr,
  output logic [7:0]    ram_wr_data,
  output logic [AW-1:0] ram_rd_addr,
  input  logic [7:0]    ram_rd_data
);
  import mfb_pkg::*;

  localparam int YW = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;

  state_t        state_r, state_nxt;
  logic [15:0]   row_r, row_nxt;
  logic [12:0]   col_r, col_nxt;
  logic [AW-1:0] fill_cnt_r, fill_cnt_nxt;
  logic [7:0]    fill_val_r, fill_val_nxt;

  logic [15:0]   item_row_r, item_row_nxt;
  logic [12:0]   item_col_r, item_col_nxt;
  logic [16:0]   py_r, py_nxt;
  logic [7:0]    data_r, data_nxt;
  logic          row_ok_r, row_ok_nxt;
  logic [16:0]   base_r, base_nxt;
  logic [AW-1:0] rowmul_r, rowmul_nxt;
  logic [15:0]   m_r, m_nxt;
  logic [15:0]   d_r, d_nxt;
  logic [AW-1:0] addr0_r, addr0_nxt;
  logic          rd_ok_r, rd_ok_nxt;

  logic [15:0]   row_e;
  logic [12:0]   col_e;
  logic [13:0]   row_bytes;
  logic [7:0]    vbits;
  logic [16:0]   cb;
  logic [17:0]   pxb;
  logic [15:0]   m16;
  logic [15:0]   d16;
  logic [AW-1:0] addr0;
  logic [AW-1:0] addr1;

  assign addr1 = addr0_r + AW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_FILL;
      row_r      <= '0;
      col_r      <= '0;
      fill_cnt_r <= '0;
      fill_val_r <= WHITE;
    end else begin
      state_r    <= state_nxt;
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      fill_cnt_r <= fill_cnt_nxt;
      fill_val_r <= fill_val_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_row_r <= item_row_nxt;
    item_col_r <= item_col_nxt;
    py_r       <= py_nxt;
    data_r     <= data_nxt;
    row_ok_r   <= row_ok_nxt;
    base_r     <= base_nxt;
    rowmul_r   <= rowmul_nxt;
    m_r        <= m_nxt;
    d_r        <= d_nxt;
    addr0_r    <= addr0_nxt;
    rd_ok_r    <= rd_ok_nxt;
  end

  // per-pixel clipping for the current source byte
  always_comb begin
    vbits = '0;
    cb    = '0;
    pxb   = '0;
    for (int b = 0; b < 8; b++) begin
      cb  = 17'({item_col_r, 3'b000}) + 17'(b);
      pxb = 18'(base_r) + 18'(b);
      vbits[7-b] = (cb < 17'(cfg.img_width)) && (pxb < 18'(SCREEN_WIDTH));
    end
    m16   = {vbits, 8'h00} >> base_r[2:0];
    d16   = {data_r, 8'h00} >> base_r[2:0];
    addr0 = rowmul_r + AW'(base_r[16:3]);
  end

  always_comb begin
    state_nxt    = state_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    fill_cnt_nxt = fill_cnt_r;
    fill_val_nxt = fill_val_r;
    item_row_nxt = item_row_r;
    item_col_nxt = item_col_r;
    py_nxt       = py_r;
    data_nxt     = data_r;
    row_ok_nxt   = row_ok_r;
    base_nxt     = base_r;
    rowmul_nxt   = rowmul_r;
    m_nxt        = m_r;
    d_nxt        = d_r;
    addr0_nxt    = addr0_r;
    rd_ok_nxt    = rd_ok_r;
    busy         = 1'b1;
    out_valid    = 1'b0;
    out_read_data = '0;
    ram_wr_en    = 1'b0;
    ram_wr_addr  = addr0_r;
    ram_wr_data  = '0;
    ram_rd_addr  = addr1;

    row_e     = in_first_byte ? '0 : row_r;
    col_e     = in_first_byte ? '0 : col_r;
    row_bytes = 14'((17'(cfg.img_width) + 17'd7) >> 3);

    case (state_r)
      ST_IDLE: begin
        busy        = 1'b0;
        ram_rd_addr = AW'(in_read_address);
        if (start) begin
          case (in_action)
            ACT_BLIT: begin
              item_row_nxt = row_e;
              item_col_nxt = col_e;
              data_nxt     = in_image_byte;
              py_nxt       = 17'(cfg.dest_y) + 17'(row_e);
              if (14'(col_e) + 14'd1 >= row_bytes) begin
                col_nxt = '0;
                row_nxt = (row_e == ROW_MAX) ? row_e : row_e + 16'd1;
              end else begin
                col_nxt = col_e + 13'd1;
                row_nxt = row_e;
              end
              state_nxt = ST_CALC;
            end
            ACT_READ: begin
              rd_ok_nxt = 32'(in_read_address) < 32'(STORE_BYTES);
              state_nxt = ST_RDOUT;
            end
            ACT_FILL: begin
              fill_val_nxt = in_fill_value;
              fill_cnt_nxt = '0;
              state_nxt    = ST_FILL;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CALC: begin
        row_ok_nxt = (item_row_r < cfg.img_height) && (py_r < 17'(SCREEN_HEIGHT));
        base_nxt   = 17'(cfg.dest_x) + 17'({item_col_r, 3'b000});
        rowmul_nxt = AW'(AW'(py_r[YW-1:0]) * AW'(ROW_BYTES));
        state_nxt  = ST_MASK;
      end
      ST_MASK: begin
        ram_rd_addr = addr0;
        m_nxt       = m16;
        d_nxt       = d16;
        addr0_nxt   = addr0;
        if (row_ok_r && (m16 != '0)) begin
          state_nxt = ST_WR0;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_WR0: begin
        ram_rd_addr = addr1;
        ram_wr_en   = m_r[15:8] != '0;
        ram_wr_addr = addr0_r;
        ram_wr_data = (ram_rd_data & ~m_r[15:8]) | (d_r[15:8] & m_r[15:8]);
        state_nxt   = (m_r[7:0] != '0) ? ST_WR1 : ST_IDLE;
      end
      ST_WR1: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = addr1;
        ram_wr_data = (ram_rd_data & ~m_r[7:0]) | (d_r[7:0] & m_r[7:0]);
        state_nxt   = ST_IDLE;
      end
      ST_RDOUT: begin
        out_valid     = 1'b1;
        out_read_data = rd_ok_r ? ram_rd_data : '0;
        state_nxt     = ST_IDLE;
      end
      ST_FILL: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = fill_cnt_r;
        ram_wr_data = fill_val_r;
        if (fill_cnt_r == AW'(STORE_BYTES - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          fill_cnt_nxt = fill_cnt_r + AW'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

### sv/mono_framebuffer_blitter_top.sv
// top level of the monochrome framebuffer blitter
//
//   channel  handshake                 payload
//   in       start / busy              in_action, in_image_byte, in_first_byte,
//                                      in_read_address, in_fill_value
//   out      out_valid (1-cycle)       out_read_data
//   cfg      cfg_valid / cfg_ready     cfg_index, cfg_data
//
// blit request: steps ST_CALC and ST_MASK, then a read-modify-write of up to two
// bytes (ST_WR0, ST_WR1) through the single write port of the frame memory
// read request: result strobed the cycle after acceptance
// fill request: one memory write per byte, over all ROW_BYTES*SCREEN_HEIGHT bytes
// after reset a white clearing sweep of all ROW_BYTES*SCREEN_HEIGHT bytes
// (48000 by default) holds busy; cfg writes are taken at any time
// the receiver cannot stall; each result is shown for one cycle only
module mono_framebuffer_blitter_top #(
  parameter int SCREEN_WIDTH = 800,
  parameter int SCREEN_HEIGHT = 480
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_image_byte,
  input  logic        in_first_byte,
  input  logic [15:0] in_read_address,
  input  logic [7:0]  in_fill_value,
  output logic        out_valid,
  output logic [7:0]  out_read_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import mfb_pkg::*;

  localparam int ROW_BYTES = (SCREEN_WIDTH + 7) / 8;
  localparam int STORE_BYTES = ROW_BYTES * SCREEN_HEIGHT;
  localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

  cfg_t cfg_r, cfg_nxt;

  logic          ram_wr_en;
  logic [AW-1:0] ram_wr_addr;
  logic [7:0]    ram_wr_data;
  logic [AW-1:0] ram_rd_addr;
  logic [7:0]    ram_rd_data;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEST_X:     cfg_nxt.dest_x     = cfg_data;
        REG_DEST_Y:     cfg_nxt.dest_y     = cfg_data;
        REG_IMG_WIDTH:  cfg_nxt.img_width  = cfg_data;
        REG_IMG_HEIGHT: cfg_nxt.img_height = cfg_data;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mfb_ctrl #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .start           (start),
    .in_action       (in_action),
    .in_image_byte   (in_image_byte),
    .in_first_byte   (in_first_byte),
    .in_read_address (in_read_address),
    .in_fill_value   (in_fill_value),
    .busy            (busy),
    .out_valid       (out_valid),
    .out_read_data   (out_read_data),
    .ram_wr_en       (ram_wr_en),
    .ram_wr_addr     (ram_wr_addr),
    .ram_wr_data     (ram_wr_data),
    .ram_rd_addr     (ram_rd_addr),
    .ram_rd_data     (ram_rd_data)
  );

  mfb_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_frame_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

endmodule
